// File: hw/rtl/cpg_pkg.sv
// Package for the circle pixel generator: shared types, codes and constants.
// No dependencies; every other file of the block refers to it by scoped names.
package cpg_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int RADIUS_BITS    = 8;
    localparam int COLOR_BITS     = 16;
    localparam int OFFSET_BITS    = 10;
    localparam int DEC_BITS       = 13;
    localparam int IDX_BITS       = 4;

    localparam logic [IDX_BITS-1:0] LAST_POINT = IDX_BITS'(8);

    localparam int DEC_INIT      = 3;
    localparam int DEC_INC_STRAIGHT = 6;
    localparam int DEC_INC_DIAG  = 10;

    localparam int BOUND_X_RST = 799;
    localparam int BOUND_Y_RST = 479;
    localparam int CLIP_W_RST  = 800;
    localparam int CLIP_H_RST  = 480;

    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CFG_BOUND_X = 2'd0,
        CFG_BOUND_Y = 2'd1,
        CFG_CLIP_W  = 2'd2,
        CFG_CLIP_H  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [COLOR_BITS-1:0]         color;
        logic signed [OFFSET_BITS-1:0] a_old;
        logic signed [OFFSET_BITS-1:0] b_old;
        logic signed [OFFSET_BITS-1:0] a_new;
        logic signed [OFFSET_BITS-1:0] b_new;
        logic                          fin;
    } t_job;

    typedef struct packed {
        logic free;
    } t_emit_status;

endpackage

// File: hw/rtl/cpg_if.sv
// Valid/ready channel interfaces for the circle pixel generator requests and pixels.
// Depends on cpg_pkg for the action code type and default coordinate width.
interface cpg_in_if #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    cpg_pkg::t_action                    action;
    logic [COORD_BITS-1:0]               center_x;
    logic [COORD_BITS-1:0]               center_y;
    logic [cpg_pkg::RADIUS_BITS-1:0]     radius;
    logic [cpg_pkg::COLOR_BITS-1:0]      color;

    modport source (output valid, action, center_x, center_y, radius, color, input ready);
    modport sink (input valid, action, center_x, center_y, radius, color, output ready);
endinterface

interface cpg_out_if #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [COORD_BITS-1:0]               pixel_x;
    logic [COORD_BITS-1:0]               pixel_y;
    logic [cpg_pkg::COLOR_BITS-1:0]      pixel_color;
    logic                                visible;
    logic                                last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, visible, last, output ready);
endinterface

// File: hw/rtl/cpg_step.sv
// Circle state and one midpoint step per accepted advance request while a circle is active.
// Depends on cpg_pkg; hands a job to cpg_emit for every step it performs.
module cpg_step #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  cpg_pkg::t_action                   i_action,
    input  logic [COORD_BITS-1:0]              i_center_x,
    input  logic [COORD_BITS-1:0]              i_center_y,
    input  logic [cpg_pkg::RADIUS_BITS-1:0]    i_radius,
    input  logic [cpg_pkg::COLOR_BITS-1:0]     i_color,
    input  logic [COORD_BITS-1:0]              i_bound_x,
    input  logic [COORD_BITS-1:0]              i_bound_y,
    output logic                               o_job_load,
    output cpg_pkg::t_job                      o_job,
    output logic [COORD_BITS-1:0]              o_job_cx,
    output logic [COORD_BITS-1:0]              o_job_cy
);

    localparam int OB = cpg_pkg::OFFSET_BITS;
    localparam int DB = cpg_pkg::DEC_BITS;

    logic                          r_active, n_active;
    logic [COORD_BITS-1:0]         r_cx, n_cx;
    logic [COORD_BITS-1:0]         r_cy, n_cy;
    logic [cpg_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic signed [OB-1:0]          r_a, n_a;
    logic signed [OB-1:0]          r_b, n_b;
    logic signed [DB-1:0]          r_dec, n_dec;

    logic                          start_ok;
    logic [COORD_BITS:0]           sum_x;
    logic [COORD_BITS:0]           sum_y;
    logic signed [OB-1:0]          a_inc;
    logic signed [OB-1:0]          b_step;
    logic signed [DB-1:0]          dec_step;
    logic signed [DB-1:0]          dec_init;
    logic                          fin;

    assign sum_x = {1'b0, i_center_x} + (COORD_BITS+1)'(i_radius);
    assign sum_y = {1'b0, i_center_y} + (COORD_BITS+1)'(i_radius);
    assign start_ok = i_accept && (i_action == cpg_pkg::ACT_START)
                      && (sum_x <= {1'b0, i_bound_x}) && (sum_y <= {1'b0, i_bound_y});
    assign o_job_load = i_accept && (i_action == cpg_pkg::ACT_ADVANCE) && r_active;

    assign dec_init = DB'(cpg_pkg::DEC_INIT) - (DB'(i_radius) <<< 1);

    always_comb begin
        a_inc = r_a + OB'(1);
        if (r_dec[DB-1]) begin
            b_step   = r_b;
            dec_step = r_dec + (DB'(a_inc) <<< 2) + DB'(cpg_pkg::DEC_INC_STRAIGHT);
        end else begin
            b_step   = r_b - OB'(1);
            dec_step = r_dec + DB'(cpg_pkg::DEC_INC_DIAG) + ((DB'(a_inc) - DB'(r_b)) <<< 2);
        end
        fin = a_inc > b_step;
    end

    always_comb begin
        n_active = r_active;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_color  = r_color;
        n_a      = r_a;
        n_b      = r_b;
        n_dec    = r_dec;
        if (start_ok) begin
            n_active = 1'b1;
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_color  = i_color;
            n_a      = '0;
            n_b      = OB'(i_radius);
            n_dec    = dec_init;
        end else if (o_job_load) begin
            n_active = !fin;
            n_a      = a_inc;
            n_b      = b_step;
            n_dec    = dec_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_color <= n_color;
        r_a     <= n_a;
        r_b     <= n_b;
        r_dec   <= n_dec;
    end

    always_comb begin
        o_job.color = r_color;
        o_job.a_old = r_a;
        o_job.b_old = r_b;
        o_job.a_new = a_inc;
        o_job.b_new = b_step;
        o_job.fin   = fin;
    end

    assign o_job_cx = r_cx;
    assign o_job_cy = r_cy;

endmodule

// File: hw/rtl/cpg_emit.sv
// Pixel emitter: holds one step's job and sends its nine points through an output register.
// Depends on cpg_pkg; fed by cpg_step.
module cpg_emit #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_load,
    input  cpg_pkg::t_job                      i_job,
    input  logic [COORD_BITS-1:0]              i_job_cx,
    input  logic [COORD_BITS-1:0]              i_job_cy,
    input  logic [COORD_BITS:0]                i_clip_w,
    input  logic [COORD_BITS:0]                i_clip_h,
    input  logic                               i_out_ready,
    output cpg_pkg::t_emit_status              o_status,
    output logic                               o_out_valid,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [cpg_pkg::COLOR_BITS-1:0]     o_pixel_color,
    output logic                               o_visible,
    output logic                               o_last
);

    localparam int OB  = cpg_pkg::OFFSET_BITS;
    localparam int EXT = COORD_BITS + 2;
    localparam int IB  = cpg_pkg::IDX_BITS;

    logic                      r_job_valid, n_job_valid;
    cpg_pkg::t_job             r_job, n_job;
    logic [COORD_BITS-1:0]     r_cx, n_cx;
    logic [COORD_BITS-1:0]     r_cy, n_cy;
    logic [IB-1:0]             r_idx, n_idx;

    logic                      r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]     r_px, n_px;
    logic [COORD_BITS-1:0]     r_py, n_py;
    logic [cpg_pkg::COLOR_BITS-1:0] r_pcol, n_pcol;
    logic                      r_vis, n_vis;
    logic                      r_last, n_last;

    logic                      out_load;
    logic                      at_last;
    logic signed [OB-1:0]      dx;
    logic signed [OB-1:0]      dy;
    logic signed [EXT-1:0]     px_ext;
    logic signed [EXT-1:0]     py_ext;
    logic                      vis;

    assign at_last  = (r_idx == cpg_pkg::LAST_POINT);
    assign out_load = r_job_valid && (!r_out_valid || i_out_ready);

    assign o_status.free = !r_job_valid || (at_last && out_load);

    always_comb begin
        unique case (r_idx)
            IB'(0): begin dx = -r_job.b_old; dy = -r_job.a_old; end
            IB'(1): begin dx =  r_job.b_old; dy = -r_job.a_old; end
            IB'(2): begin dx = -r_job.a_old; dy =  r_job.b_old; end
            IB'(3): begin dx = -r_job.a_old; dy = -r_job.b_old; end
            IB'(4): begin dx =  r_job.b_old; dy =  r_job.a_old; end
            IB'(5): begin dx =  r_job.a_old; dy = -r_job.b_old; end
            IB'(6): begin dx =  r_job.a_old; dy =  r_job.b_old; end
            IB'(7): begin dx = -r_job.b_old; dy =  r_job.a_old; end
            default: begin dx = r_job.a_new; dy = r_job.b_new; end
        endcase
    end

    assign px_ext = $signed({2'b00, r_cx}) + EXT'(dx);
    assign py_ext = $signed({2'b00, r_cy}) + EXT'(dy);
    assign vis = !px_ext[EXT-1] && !py_ext[EXT-1]
                 && (px_ext[COORD_BITS:0] < i_clip_w) && (py_ext[COORD_BITS:0] < i_clip_h);

    always_comb begin
        n_job_valid = r_job_valid;
        n_job       = r_job;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_idx       = r_idx;
        if (i_job_load) begin
            n_job_valid = 1'b1;
            n_job       = i_job;
            n_cx        = i_job_cx;
            n_cy        = i_job_cy;
            n_idx       = '0;
        end else if (out_load) begin
            n_job_valid = !at_last;
            n_idx       = r_idx + IB'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_px        = r_px;
        n_py        = r_py;
        n_pcol      = r_pcol;
        n_vis       = r_vis;
        n_last      = r_last;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_px        = vis ? px_ext[COORD_BITS-1:0] : '0;
            n_py        = vis ? py_ext[COORD_BITS-1:0] : '0;
            n_pcol      = r_job.color;
            n_vis       = vis;
            n_last      = at_last && r_job.fin;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_out_valid <= n_out_valid;
        end
        r_job  <= n_job;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_idx  <= n_idx;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pcol <= n_pcol;
        r_vis  <= n_vis;
        r_last <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcol;
    assign o_visible     = r_vis;
    assign o_last        = r_last;

endmodule

// File: hw/rtl/circle_pixel_generator_unit.sv
// Midpoint circle rasterizer: a start request gives no pixel; an advance request loads its step
// into the job register of cpg_emit on acceptance, then its first pixel moves into the output
// register, and while the output is not stalled its nine pixels follow back to back.
// Requests are accepted only while no step is pending or as its last point enters the output
// register; start requests are taken every cycle while no step is being sent out.
// Synchronous active-low reset clears the circle, the pending step, the output register and
// restores the bound and clip registers to 799, 479, 800 and 480.
module circle_pixel_generator_unit #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpg_in_if.sink                i_req,
    cpg_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [COORD_BITS:0]   i_cfg_data
);

    logic [COORD_BITS-1:0]  r_bound_x;
    logic [COORD_BITS-1:0]  r_bound_y;
    logic [COORD_BITS:0]    r_clip_w;
    logic [COORD_BITS:0]    r_clip_h;

    logic                   accept;
    logic                   job_load;
    cpg_pkg::t_job          job;
    logic [COORD_BITS-1:0]  job_cx;
    logic [COORD_BITS-1:0]  job_cy;
    cpg_pkg::t_emit_status  emit_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_x <= COORD_BITS'(cpg_pkg::BOUND_X_RST);
            r_bound_y <= COORD_BITS'(cpg_pkg::BOUND_Y_RST);
            r_clip_w  <= (COORD_BITS+1)'(cpg_pkg::CLIP_W_RST);
            r_clip_h  <= (COORD_BITS+1)'(cpg_pkg::CLIP_H_RST);
        end else if (i_cfg_we) begin
            unique case (cpg_pkg::t_cfg_reg'(i_cfg_index))
                cpg_pkg::CFG_BOUND_X: r_bound_x <= i_cfg_data[COORD_BITS-1:0];
                cpg_pkg::CFG_BOUND_Y: r_bound_y <= i_cfg_data[COORD_BITS-1:0];
                cpg_pkg::CFG_CLIP_W:  r_clip_w  <= i_cfg_data;
                cpg_pkg::CFG_CLIP_H:  r_clip_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = emit_status.free;
    assign accept = i_req.valid && i_req.ready;

    cpg_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_req.action),
        .i_center_x (i_req.center_x),
        .i_center_y (i_req.center_y),
        .i_radius   (i_req.radius),
        .i_color    (i_req.color),
        .i_bound_x  (r_bound_x),
        .i_bound_y  (r_bound_y),
        .o_job_load (job_load),
        .o_job      (job),
        .o_job_cx   (job_cx),
        .o_job_cy   (job_cy)
    );

    cpg_emit #(
        .COORD_BITS(COORD_BITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_load    (job_load),
        .i_job         (job),
        .i_job_cx      (job_cx),
        .i_job_cy      (job_cy),
        .i_clip_w      (r_clip_w),
        .i_clip_h      (r_clip_h),
        .i_out_ready   (o_pix.ready),
        .o_status      (emit_status),
        .o_out_valid   (o_pix.valid),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_visible     (o_pix.visible),
        .o_last        (o_pix.last)
    );

`ifndef SYNTH
    // A step is only handed over for an accepted advance request.
    a_job_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_load |-> (accept && i_req.action == cpg_pkg::ACT_ADVANCE))
        else $error("step job without an accepted advance request");

    // An accepted step is always followed by a valid pixel on the output channel.
    a_job_gives_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_load |-> ##2 o_pix.valid)
        else $error("accepted step did not present a pixel");

    // Invisible pixels carry zero coordinates.
    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.visible) |-> (o_pix.pixel_x == '0 && o_pix.pixel_y == '0))
        else $error("invisible pixel with nonzero coordinates");
`endif

endmodule

// File: test/circle_pixel_generator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for circle_pixel_generator_unit: a scripted opening, then random circles
// and stray requests under several bound and clip settings, with random stalls on both channels.
// Depends on cpg_pkg and on the cpg_in_if and cpg_out_if interfaces of the block.
module circle_pixel_generator_unit_tb;

    localparam int CB            = 11;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        cpg_pkg::t_action                act;
        logic [CB-1:0]                   cx;
        logic [CB-1:0]                   cy;
        logic [cpg_pkg::RADIUS_BITS-1:0] r;
        logic [cpg_pkg::COLOR_BITS-1:0]  color;
    } t_request;

    typedef struct packed {
        logic [CB-1:0]                  x;
        logic [CB-1:0]                  y;
        logic [cpg_pkg::COLOR_BITS-1:0] color;
        logic                           vis;
        logic                           last;
    } t_pixel;

    typedef struct {
        t_request req;
        bit       typed;
        t_pixel   closing_pixel;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CB:0] i_cfg_data;

    cpg_in_if #(.COORD_BITS(CB)) req_ch ();
    cpg_out_if #(.COORD_BITS(CB)) pix_ch ();

    circle_pixel_generator_unit #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_pix       (pix_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the block's registers and circle state.
    int  lim_x = cpg_pkg::BOUND_X_RST;
    int  lim_y = cpg_pkg::BOUND_Y_RST;
    int  clip_w = cpg_pkg::CLIP_W_RST;
    int  clip_h = cpg_pkg::CLIP_H_RST;
    bit  circ_active = 1'b0;
    int  circ_cx = 0;
    int  circ_cy = 0;
    logic [cpg_pkg::COLOR_BITS-1:0] circ_color = '0;
    int  off_a = 0;
    int  off_b = 0;
    int  circ_dec = 0;

    t_pixel pixels_due[$];
    int     mismatches = 0;
    int     sent = 0;
    int     pix_taken = 0;
    bit     src_calm = 1'b0;

    t_script_row script [24] = '{
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 0, 0, 0, 16'hFFFF}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b1, '{0, 0, 16'hFFFF, 1'b0, 1'b1}},
        '{'{cpg_pkg::ACT_ADVANCE, 2047, 2047, 255, 16'hFFFF}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 799, 10, 1, 16'h1111}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 799, 479, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b1, '{0, 0, 16'h0000, 1'b0, 1'b1}},
        '{'{cpg_pkg::ACT_START, 100, 100, 5, 16'hA5A5}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 700, 400, 255, 16'hFFFF}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 1234, 321, 77, 16'h0F0F}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 5, 5, 10, 16'h5A5A}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 798, 478, 1, 16'h1234}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 2047, 2047, 255, 16'h0000}, 1'b0, '0},
        '{'{cpg_pkg::ACT_START, 400, 224, 255, 16'hC3C3}, 1'b0, '0},
        '{'{cpg_pkg::ACT_ADVANCE, 0, 0, 0, 16'h0000}, 1'b0, '0}
    };

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic t_pixel plot(input int dx, input int dy, input bit fin);
        t_pixel p;
        int     px;
        int     py;
        px = circ_cx + dx;
        py = circ_cy + dy;
        p.vis   = (px >= 0) && (py >= 0) && (px < clip_w) && (py < clip_h);
        p.x     = p.vis ? CB'(px) : '0;
        p.y     = p.vis ? CB'(py) : '0;
        p.color = circ_color;
        p.last  = fin;
        return p;
    endfunction

    // Works out the pixels one accepted request yields and updates the circle state.
    function automatic void trace_request(input t_request q);
        int a;
        int b;
        if (q.act == cpg_pkg::ACT_START) begin
            if (int'(q.cx) + int'(q.r) > lim_x || int'(q.cy) + int'(q.r) > lim_y) begin
                return;
            end
            circ_cx     = int'(q.cx);
            circ_cy     = int'(q.cy);
            circ_color  = q.color;
            off_a       = 0;
            off_b       = int'(q.r);
            circ_dec    = cpg_pkg::DEC_INIT - 2 * int'(q.r);
            circ_active = 1'b1;
            return;
        end
        if (!circ_active) begin
            return;
        end
        a = off_a;
        b = off_b;
        pixels_due.push_back(plot(-b, -a, 1'b0));
        pixels_due.push_back(plot(b, -a, 1'b0));
        pixels_due.push_back(plot(-a, b, 1'b0));
        pixels_due.push_back(plot(-a, -b, 1'b0));
        pixels_due.push_back(plot(b, a, 1'b0));
        pixels_due.push_back(plot(a, -b, 1'b0));
        pixels_due.push_back(plot(a, b, 1'b0));
        pixels_due.push_back(plot(-b, a, 1'b0));
        a++;
        if (circ_dec < 0) begin
            circ_dec += 4 * a + cpg_pkg::DEC_INC_STRAIGHT;
        end else begin
            circ_dec += cpg_pkg::DEC_INC_DIAG + 4 * (a - b);
            b--;
        end
        off_a = a;
        off_b = b;
        pixels_due.push_back(plot(a, b, a > b));
        if (a > b) begin
            circ_active = 1'b0;
        end
    endfunction

    function automatic t_request stray_request(input cpg_pkg::t_action act);
        t_request q;
        q.act   = act;
        q.cx    = CB'($urandom_range(0, 2047));
        q.cy    = CB'($urandom_range(0, 2047));
        q.r     = cpg_pkg::RADIUS_BITS'($urandom_range(0, 255));
        q.color = cpg_pkg::COLOR_BITS'($urandom_range(0, 65535));
        return q;
    endfunction

    task automatic send_request(input t_request q, input bit typed, input t_pixel typed_px);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= q.act;
        req_ch.center_x <= q.cx;
        req_ch.center_y <= q.cy;
        req_ch.radius   <= q.r;
        req_ch.color    <= q.color;
        do @(posedge i_clk); while (!req_ch.ready);
        trace_request(q);
        if (typed && pixels_due.size() > 0) begin
            pixels_due[pixels_due.size() - 1] = typed_px;
        end
        sent++;
    endtask

    task automatic draw_circle(input int upto);
        t_request q;
        int rmax;
        int r;
        int cap;
        int steps;
        src_calm = ($urandom_range(0, 3) == 0);
        rmax = (lim_x < lim_y) ? lim_x : lim_y;
        if (rmax > 255) begin
            rmax = 255;
        end
        if ($urandom_range(0, 19) == 0) begin
            r = $urandom_range(0, rmax);
        end else begin
            r = $urandom_range(0, (rmax < 15) ? rmax : 15);
        end
        q = stray_request(cpg_pkg::ACT_START);
        q.r  = cpg_pkg::RADIUS_BITS'(r);
        q.cx = CB'($urandom_range(0, lim_x - r));
        q.cy = CB'($urandom_range(0, lim_y - r));
        cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 1000;
        send_request(q, 1'b0, '0);
        steps = 0;
        while (circ_active && steps < cap && sent < upto) begin
            send_request(stray_request(cpg_pkg::ACT_ADVANCE), 1'b0, '0);
            steps++;
        end
    endtask

    task automatic run_random(input int upto);
        while (sent < upto) begin
            if ($urandom_range(0, 4) == 0) begin
                src_calm = 1'b0;
                send_request(stray_request(cpg_pkg::t_action'($urandom_range(0, 1))), 1'b0, '0);
            end else begin
                draw_circle(upto);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pixels_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input cpg_pkg::t_cfg_reg idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= (CB + 1)'(value);
        case (idx)
            cpg_pkg::CFG_BOUND_X: lim_x = value & 'h7FF;
            cpg_pkg::CFG_BOUND_Y: lim_y = value & 'h7FF;
            cpg_pkg::CFG_CLIP_W:  clip_w = value & 'hFFF;
            cpg_pkg::CFG_CLIP_H:  clip_h = value & 'hFFF;
            default: ;
        endcase
    endtask

    task automatic set_limits(input int bx, input int by, input int cw, input int ch);
        write_register(cpg_pkg::CFG_BOUND_X, bx);
        write_register(cpg_pkg::CFG_BOUND_Y, by);
        write_register(cpg_pkg::CFG_CLIP_W, cw);
        write_register(cpg_pkg::CFG_CLIP_H, ch);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            pix_taken++;
            if (pixels_due.size() == 0) begin
                report_mismatch("pixel with no request pending", int'(pix_ch.pixel_x), -1);
            end else begin
                want = pixels_due.pop_front();
                if (pix_ch.pixel_x !== want.x) begin
                    report_mismatch("pixel_x", int'(pix_ch.pixel_x), int'(want.x));
                end
                if (pix_ch.pixel_y !== want.y) begin
                    report_mismatch("pixel_y", int'(pix_ch.pixel_y), int'(want.y));
                end
                if (pix_ch.pixel_color !== want.color) begin
                    report_mismatch("pixel_color", int'(pix_ch.pixel_color), int'(want.color));
                end
                if (pix_ch.visible !== want.vis) begin
                    report_mismatch("visible", int'(pix_ch.visible), int'(want.vis));
                end
                if (pix_ch.last !== want.last) begin
                    report_mismatch("last", int'(pix_ch.last), int'(want.last));
                end
            end
        end
    end

    initial begin
        int hold;
        int seen;
        int sink_left;
        bit sink_calm;
        hold = 0;
        seen = 0;
        sink_left = 0;
        sink_calm = 1'b0;
        pix_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pix_taken != seen) begin
                seen = pix_taken;
                if (sink_left == 0) begin
                    sink_calm = ($urandom_range(0, 2) == 0);
                    sink_left = $urandom_range(10, 60);
                end
                sink_left--;
                hold = sink_calm ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0) begin
                pix_ch.ready <= 1'b0;
                hold--;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = cpg_pkg::CFG_BOUND_X;
        i_cfg_data      = '0;
        req_ch.valid    = 1'b0;
        req_ch.action   = cpg_pkg::ACT_START;
        req_ch.center_x = '0;
        req_ch.center_y = '0;
        req_ch.radius   = '0;
        req_ch.color    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(script); k++) begin
            send_request(script[k].req, script[k].typed, script[k].closing_pixel);
        end
        run_random(70);

        drain();
        set_limits(2047, 2047, 2048, 2048);
        run_random(140);

        drain();
        set_limits(0, 0, 1, 1);
        run_random(165);

        drain();
        set_limits($urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(1, 2048), $urandom_range(1, 2048));
        run_random(225);

        // A zero clip size hides every point.
        drain();
        set_limits(2047, 2047, 0, 0);
        run_random(255);

        drain();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
